// ===== rtl/core/pidvi_pkg.sv =====
package pidvi_pkg;

   // configuration port
   localparam int NumRegs   = 8;
   localparam int AddrWidth = 6;
   localparam int DataWidth = 64;
   localparam int IdxLsb    = 3;

   typedef enum logic [2:0] {
      REG_PROP_GAIN        = 3'd0,
      REG_INTEG_GAIN       = 3'd1,
      REG_DERIV_GAIN       = 3'd2,
      REG_FEEDFWD_GAIN     = 3'd3,
      REG_INTEGRAL_LIMIT   = 3'd4,
      REG_OUTPUT_LIMIT     = 3'd5,
      REG_ERROR_THRESHOLDS = 3'd6,
      REG_WRAP_AND_MODE    = 3'd7
   } reg_index_type;

   // shared multiplier operands and product
   localparam int MulAWidth = 36;
   localparam int MulBWidth = 20;
   localparam int MulPWidth = MulAWidth + MulBWidth;

   // band scale divider
   localparam int DivWidth = 16;
   localparam int DivCountWidth = $clog2(DivWidth + 1);

   localparam logic [16:0] ScaleOne = 17'h10000;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               clamped;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] integ_gain;
      logic signed [15:0] deriv_gain;
      logic signed [15:0] feedfwd_gain;
      logic [14:0]        integral_limit;
      logic [14:0]        output_limit;
      logic [15:0]        deadband;
      logic [15:0]        band_low;
      logic [15:0]        band_high;
      logic [15:0]        wrap_range;
      logic               deriv_on_meas;
   } cfg_type;

endpackage

// ===== rtl/core/pidvi_csr.sv =====
module pidvi_csr import pidvi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   logic [15:0] prop_gain_ff;
   logic [15:0] integ_gain_ff;
   logic [15:0] deriv_gain_ff;
   logic [15:0] feedfwd_gain_ff;
   logic [14:0] integral_limit_ff;
   logic [14:0] output_limit_ff;
   logic [47:0] thresholds_ff;
   logic [16:0] wrap_mode_ff;
   logic        wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[AddrWidth-1:IdxLsb]);

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= '0;
         integ_gain_ff     <= '0;
         deriv_gain_ff     <= '0;
         feedfwd_gain_ff   <= '0;
         integral_limit_ff <= '0;
         output_limit_ff   <= '0;
         thresholds_ff     <= '0;
         wrap_mode_ff      <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_PROP_GAIN:        prop_gain_ff      <= csr_pwdata[15:0];
            REG_INTEG_GAIN:       integ_gain_ff     <= csr_pwdata[15:0];
            REG_DERIV_GAIN:       deriv_gain_ff     <= csr_pwdata[15:0];
            REG_FEEDFWD_GAIN:     feedfwd_gain_ff   <= csr_pwdata[15:0];
            REG_INTEGRAL_LIMIT:   integral_limit_ff <= csr_pwdata[14:0];
            REG_OUTPUT_LIMIT:     output_limit_ff   <= csr_pwdata[14:0];
            REG_ERROR_THRESHOLDS: thresholds_ff     <= csr_pwdata[47:0];
            REG_WRAP_AND_MODE:    wrap_mode_ff      <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         REG_PROP_GAIN:        csr_prdata[15:0] = prop_gain_ff;
         REG_INTEG_GAIN:       csr_prdata[15:0] = integ_gain_ff;
         REG_DERIV_GAIN:       csr_prdata[15:0] = deriv_gain_ff;
         REG_FEEDFWD_GAIN:     csr_prdata[15:0] = feedfwd_gain_ff;
         REG_INTEGRAL_LIMIT:   csr_prdata[14:0] = integral_limit_ff;
         REG_OUTPUT_LIMIT:     csr_prdata[14:0] = output_limit_ff;
         REG_ERROR_THRESHOLDS: csr_prdata[47:0] = thresholds_ff;
         REG_WRAP_AND_MODE:    csr_prdata[16:0] = wrap_mode_ff;
         default:              csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.prop_gain      = prop_gain_ff;
      cfg.integ_gain     = integ_gain_ff;
      cfg.deriv_gain     = deriv_gain_ff;
      cfg.feedfwd_gain   = feedfwd_gain_ff;
      cfg.integral_limit = integral_limit_ff;
      cfg.output_limit   = output_limit_ff;
      cfg.deadband       = thresholds_ff[15:0];
      cfg.band_low       = thresholds_ff[31:16];
      cfg.band_high      = thresholds_ff[47:32];
      cfg.wrap_range     = wrap_mode_ff[15:0];
      cfg.deriv_on_meas  = wrap_mode_ff[16];
   end

endmodule

// ===== rtl/core/pidvi_mul.sv =====
module pidvi_mul import pidvi_pkg::*; (
   input  logic                        clock,
   input  logic                        load,
   input  logic signed [MulAWidth-1:0] mul_a,
   input  logic signed [MulBWidth-1:0] mul_b,
   output logic signed [MulPWidth-1:0] prod_ff
);

   logic signed [MulPWidth-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   // hold the product until the sequencer issues the next operands
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== rtl/core/pidvi_div.sv =====
module pidvi_div import pidvi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DivWidth-1:0] num,
   input  logic [DivWidth-1:0] den,
   output logic                done,
   output logic [DivWidth-1:0] quot
);

   // restoring division of (num << DivWidth) by den, num < den
   logic [DivWidth-1:0]      rem_ff;
   logic [DivWidth-1:0]      rem_in;
   logic [DivWidth-1:0]      den_ff;
   logic [DivWidth-1:0]      quot_ff;
   logic [DivWidth-1:0]      quot_in;
   logic [DivCountWidth-1:0] count_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DivWidth:0]        rem_shift;
   logic                     fits;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? DivWidth'(rem_shift - {1'b0, den_ff}) : rem_shift[DivWidth-1:0];
      quot_in   = {quot_ff[DivWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= DivCountWidth'(DivWidth);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == DivCountWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= num;
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/core/pid_controller_variable_integral_core.sv =====
// A beat steps through the wrap, error, band, scale, integral and term states to ST_OUT,
// with the 16-step divider in between when the scale inside the band is not one or zero.
// A new beat is taken only in ST_IDLE; a single 36x20 multiplier is reused for all terms.
// A finished beat waits in the output register while the next one is accepted.
// Synchronous reset clears the state, the output valid, the integral and the error/measurement/target history.
module pid_controller_variable_integral_core import pidvi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRAP, ST_ERR, ST_BAND, ST_DIV, ST_SCALE,
      ST_INTEG, ST_PTERM, ST_DTERM, ST_FTERM, ST_OUT
   } state_type;

   cfg_type cfg;

   state_type          state_ff;
   logic signed [15:0] set_ff;
   logic signed [17:0] meas_ff;
   logic signed [18:0] err_ff;
   logic [17:0]        abs_ff;
   logic [16:0]        scale_ff;
   logic signed [23:0] integ_ff;
   logic signed [39:0] sum_ff;
   logic signed [18:0] last_err_ff;
   logic signed [17:0] last_meas_ff;
   logic signed [15:0] last_set_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic                        mul_load;
   logic signed [MulAWidth-1:0] mul_a;
   logic signed [MulBWidth-1:0] mul_b;
   logic signed [MulPWidth-1:0] prod_ff;

   logic                div_start;
   logic                div_done;
   logic [DivWidth-1:0] div_num;
   logic [DivWidth-1:0] div_den;
   logic [DivWidth-1:0] div_quot;

   logic signed [16:0] err0;
   logic signed [17:0] err0_x2;
   logic signed [17:0] wrap_s;
   logic signed [17:0] meas_wrapped;
   logic signed [18:0] err_raw;
   logic [17:0]        abs_raw;
   logic [15:0]        hi_eff;
   logic               scale_full;
   logic               in_band;
   logic [14:0]        ilim_eff;
   logic signed [35:0] ilim_pos;
   logic signed [35:0] acc_sum;
   logic signed [35:0] integ_next;
   logic signed [39:0] olim_pos;
   logic signed [39:0] sum_lim;
   logic               hit;
   logic signed [19:0] dterm_diff;
   logic signed [16:0] ff_diff;
   logic               out_free;

   pidvi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidvi_mul u_mul (
      .clock   (clock),
      .load    (mul_load),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   pidvi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // wrap shift
   always_comb begin
      err0         = {set_ff[15], set_ff} - meas_ff[16:0];
      err0_x2      = {err0, 1'b0};
      wrap_s       = $signed({2'b00, cfg.wrap_range});
      meas_wrapped = meas_ff;
      if (cfg.wrap_range != '0) begin
         if (err0_x2 > wrap_s) begin
            meas_wrapped = meas_ff + wrap_s;
         end else if (err0_x2 < -wrap_s) begin
            meas_wrapped = meas_ff - wrap_s;
         end
      end
   end

   // error and magnitude
   always_comb begin
      err_raw = {{3{set_ff[15]}}, set_ff} - {meas_ff[17], meas_ff};
      abs_raw = err_raw[18] ? 18'(-err_raw) : err_raw[17:0];
   end

   // band scale decision
   always_comb begin
      hi_eff     = (cfg.band_high == '0 || cfg.band_low > cfg.band_high) ?
                   cfg.band_low : cfg.band_high;
      scale_full = (cfg.band_low == '0) || (abs_ff <= {2'b00, cfg.band_low});
      in_band    = abs_ff < {2'b00, hi_eff};
      div_num    = hi_eff - abs_ff[15:0];
      div_den    = hi_eff - cfg.band_low;
      div_start  = (state_ff == ST_BAND) && !scale_full && in_band;
   end

   // integral update and clamp
   always_comb begin
      ilim_eff   = (cfg.integral_limit < cfg.output_limit) ?
                   cfg.integral_limit : cfg.output_limit;
      ilim_pos   = $signed({13'b0, ilim_eff, 8'b0});
      acc_sum    = $signed({{12{integ_ff[23]}}, integ_ff}) + prod_ff[51:16];
      integ_next = acc_sum;
      if (acc_sum > ilim_pos) begin
         integ_next = ilim_pos;
      end else if (acc_sum < -ilim_pos) begin
         integ_next = -ilim_pos;
      end
   end

   // output clamp
   always_comb begin
      olim_pos = $signed({17'b0, cfg.output_limit, 8'b0});
      sum_lim  = sum_ff;
      hit      = 1'b0;
      if (sum_ff > olim_pos) begin
         sum_lim = olim_pos;
         hit     = 1'b1;
      end else if (sum_ff < -olim_pos) begin
         sum_lim = -olim_pos;
         hit     = 1'b1;
      end
   end

   // multiplier operand select
   always_comb begin
      if (cfg.deriv_on_meas) begin
         dterm_diff = {{2{last_meas_ff[17]}}, last_meas_ff} - {{2{meas_ff[17]}}, meas_ff};
      end else begin
         dterm_diff = {err_ff[18], err_ff} - {last_err_ff[18], last_err_ff};
      end
      ff_diff  = {set_ff[15], set_ff} - {last_set_ff[15], last_set_ff};
      mul_load = 1'b1;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         ST_BAND: begin
            mul_a = {{(MulAWidth-16){cfg.integ_gain[15]}}, cfg.integ_gain};
            mul_b = {{(MulBWidth-19){err_ff[18]}}, err_ff};
         end
         ST_SCALE: begin
            mul_a = prod_ff[MulAWidth-1:0];
            mul_b = {{(MulBWidth-17){1'b0}}, scale_ff};
         end
         ST_INTEG: begin
            mul_a = {{(MulAWidth-16){cfg.prop_gain[15]}}, cfg.prop_gain};
            mul_b = {{(MulBWidth-19){err_ff[18]}}, err_ff};
         end
         ST_PTERM: begin
            mul_a = {{(MulAWidth-16){cfg.deriv_gain[15]}}, cfg.deriv_gain};
            mul_b = dterm_diff;
         end
         ST_DTERM: begin
            mul_a = {{(MulAWidth-16){cfg.feedfwd_gain[15]}}, cfg.feedfwd_gain};
            mul_b = {{(MulBWidth-17){ff_diff[16]}}, ff_diff};
         end
         default: mul_load = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         last_meas_ff <= '0;
         last_set_ff  <= '0;
      end else begin
         // ST_OUT refills the output register on its own
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  set_ff   <= req_data.setpoint;
                  meas_ff  <= {{2{req_data.measured[15]}}, req_data.measured};
                  state_ff <= ST_WRAP;
               end
            end
            ST_WRAP: begin
               meas_ff  <= meas_wrapped;
               state_ff <= ST_ERR;
            end
            ST_ERR: begin
               // drop errors inside the dead zone
               if (abs_raw < {2'b00, cfg.deadband}) begin
                  err_ff <= '0;
                  abs_ff <= '0;
               end else begin
                  err_ff <= err_raw;
                  abs_ff <= abs_raw;
               end
               state_ff <= ST_BAND;
            end
            ST_BAND: begin
               scale_ff <= scale_full ? ScaleOne : '0;
               state_ff <= div_start ? ST_DIV : ST_SCALE;
            end
            ST_DIV: begin
               if (div_done) begin
                  scale_ff <= {1'b0, div_quot};
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_INTEG;
            end
            ST_INTEG: begin
               integ_ff <= integ_next[23:0];
               sum_ff   <= {{4{integ_next[35]}}, integ_next};
               state_ff <= ST_PTERM;
            end
            ST_PTERM: begin
               sum_ff   <= sum_ff + prod_ff[39:0];
               state_ff <= ST_DTERM;
            end
            ST_DTERM: begin
               sum_ff   <= sum_ff + prod_ff[39:0];
               state_ff <= ST_FTERM;
            end
            ST_FTERM: begin
               sum_ff   <= sum_ff + prod_ff[39:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_data_ff.drive   <= sum_lim[23:8];
                  rsp_data_ff.clamped <= hit;
                  rsp_valid_ff        <= 1'b1;
                  last_err_ff         <= err_ff;
                  last_meas_ff        <= meas_ff;
                  last_set_ff         <= set_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
